/* rtl/preemptive_priority_scheduler_core_macros.svh */
// assertion macros shared by the scheduler rtl
// no dependencies; each macro is empty when SYNTHESIS is defined
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_CORE_MACROS_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define PPS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pps assertion failed");
`else
`define PPS_ASSERT(label, clk, rst_n, prop)
`endif

`ifndef SYNTHESIS
`define PPS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pps assertion failed");
`else
`define PPS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`endif

`ifndef SYNTHESIS
`define PPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pps assertion failed");
`else
`define PPS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/pps_pkg.sv */
// types, constants and state codes for the priority scheduler
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package pps_pkg;

    localparam int PROCESSES = 16;
    localparam int SLOT_W    = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
    localparam logic [15:0] TIME_MAX = 16'hFFFF;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [3:0]  slot;
        logic [11:0] arrival_time;
        logic [7:0]  burst_length;
        logic [7:0]  priority_level;
    } req_t;

    typedef struct packed {
        logic        ran_valid;
        logic [3:0]  ran_slot;
        logic [15:0] tick_start;
        logic        finished;
        logic [15:0] completion_time;
        logic [15:0] turnaround_time;
        logic [15:0] waiting_time;
        logic [15:0] response_time;
        logic        all_done;
    } rsp_t;

    typedef struct packed {
        logic [11:0] arrival;
        logic [7:0]  burst;
        logic [7:0]  prio;
        logic [7:0]  remaining;
        logic [15:0] first_start;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic scan_start;
        logic scan;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic req_is_tick;
        logic scan_last;
        logic out_free;
    } dp_sts_t;

endpackage

/* rtl/pps_ctrl.sv */
// controller state machine: accepts a transfer, steps the slot scan, commits
// depends on pps_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "preemptive_priority_scheduler_core_macros.svh"

module pps_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    output pps_pkg::dp_cmd_t cmd,
    input  pps_pkg::dp_sts_t sts
);
    import pps_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = sts.req_is_tick ? ST_SCAN : ST_COMMIT;
                end
            end
            ST_SCAN:
            begin
                if (sts.scan_last)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_stall      = 1'b0;
                cmd.scan_start = req_valid;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            ST_COMMIT:
            begin
                cmd.commit = sts.out_free;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    `PPS_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, cmd.scan_start, state_reg != ST_IDLE)
    `PPS_ASSERT_NEXT(a_scan_ends_in_commit, clk, rst_n, (state_reg == ST_SCAN) && sts.scan_last, state_reg == ST_COMMIT)
    `PPS_ASSERT_NEXT(a_commit_returns_idle, clk, rst_n, cmd.commit, state_reg == ST_IDLE)

endmodule

/* rtl/pps_datapath.sv */
// datapath: slot table, time counter, winner search registers, result register
// depends on pps_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "preemptive_priority_scheduler_core_macros.svh"

module pps_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  pps_pkg::req_t    req,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output pps_pkg::rsp_t    rsp,
    input  pps_pkg::dp_cmd_t cmd,
    output pps_pkg::dp_sts_t sts
);
    import pps_pkg::*;

    entry_t                 entry_reg [PROCESSES];
    logic [PROCESSES-1:0]   active_reg, active_next;
    logic [PROCESSES-1:0]   done_reg, done_next;
    logic [15:0]            now_reg, now_next;
    req_t                   req_reg, req_next;
    logic [SLOT_W-1:0]      idx_reg, idx_next;
    logic                   found_reg, found_next;
    logic [SLOT_W-1:0]      best_slot_reg, best_slot_next;
    logic [7:0]             best_prio_reg, best_prio_next;
    logic [11:0]            best_arr_reg, best_arr_next;
    rsp_t                   rsp_reg, rsp_next;
    logic                   rsp_valid_reg, rsp_valid_next;

    logic                   wr_en;
    logic [SLOT_W-1:0]      wr_addr;
    entry_t                 entry_next;

    logic [SLOT_W-1:0]      rd_addr;
    entry_t                 rd_entry;
    logic                   eligible;
    logic                   better;
    logic [15:0]            now_inc;
    logic                   load_in_range;
    logic [SLOT_W-1:0]      load_addr;
    logic                   first_disp;
    logic [7:0]             rem_dec;
    logic                   fin;
    logic [15:0]            fs_eff;
    logic [15:0]            arr16;
    logic [15:0]            burst16;
    logic [15:0]            tat;
    logic [15:0]            wt;
    logic [15:0]            resp_t16;

    assign rd_addr  = cmd.scan ? idx_reg : best_slot_reg;
    assign rd_entry = entry_reg[rd_addr];

    assign eligible = active_reg[idx_reg] && !done_reg[idx_reg]
                      && ({4'b0000, rd_entry.arrival} <= now_reg);
    assign better   = !found_reg || (rd_entry.prio < best_prio_reg)
                      || ((rd_entry.prio == best_prio_reg) && (rd_entry.arrival < best_arr_reg));

    assign now_inc       = (now_reg == TIME_MAX) ? now_reg : now_reg + 16'd1;
    assign load_in_range = ({28'd0, req_reg.slot} < 32'(PROCESSES));
    assign load_addr     = SLOT_W'(req_reg.slot);

    assign first_disp = (rd_entry.remaining == rd_entry.burst);
    assign rem_dec    = rd_entry.remaining - 8'd1;
    assign fin        = (rem_dec == 8'd0);
    assign fs_eff     = first_disp ? now_reg : rd_entry.first_start;
    assign arr16      = {4'b0000, rd_entry.arrival};
    assign burst16    = {8'd0, rd_entry.burst};
    assign tat        = (now_inc >= arr16) ? now_inc - arr16 : 16'd0;
    assign wt         = (tat >= burst16) ? tat - burst16 : 16'd0;
    assign resp_t16   = (fs_eff >= arr16) ? fs_eff - arr16 : 16'd0;

    always_comb
    begin
        active_next    = active_reg;
        done_next      = done_reg;
        now_next       = now_reg;
        req_next       = req_reg;
        idx_next       = idx_reg;
        found_next     = found_reg;
        best_slot_next = best_slot_reg;
        best_prio_next = best_prio_reg;
        best_arr_next  = best_arr_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        wr_en          = 1'b0;
        wr_addr        = load_addr;
        entry_next     = rd_entry;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        if (cmd.scan_start)
        begin
            req_next   = req;
            idx_next   = '0;
            found_next = 1'b0;
        end

        if (cmd.scan)
        begin
            if (eligible && better)
            begin
                found_next     = 1'b1;
                best_slot_next = idx_reg;
                best_prio_next = rd_entry.prio;
                best_arr_next  = rd_entry.arrival;
            end
            idx_next = idx_reg + SLOT_W'(1);
        end

        if (cmd.commit)
        begin
            rsp_next            = '0;
            rsp_next.tick_start = now_reg;
            rsp_valid_next      = 1'b1;
            if (req_reg.operation == OP_LOAD)
            begin
                if (load_in_range)
                begin
                    wr_en                  = 1'b1;
                    wr_addr                = load_addr;
                    entry_next.arrival     = req_reg.arrival_time;
                    entry_next.burst       = req_reg.burst_length;
                    entry_next.prio        = req_reg.priority_level;
                    entry_next.remaining   = req_reg.burst_length;
                    entry_next.first_start = 16'd0;
                    active_next[load_addr] = (req_reg.burst_length != 8'd0);
                    done_next[load_addr]   = 1'b0;
                end
            end
            else
            begin
                now_next = now_inc;
                if (found_reg)
                begin
                    wr_en                  = 1'b1;
                    wr_addr                = best_slot_reg;
                    entry_next.remaining   = rem_dec;
                    entry_next.first_start = fs_eff;
                    rsp_next.ran_valid     = 1'b1;
                    rsp_next.ran_slot      = 4'(best_slot_reg);
                    if (fin)
                    begin
                        done_next[best_slot_reg] = 1'b1;
                        rsp_next.finished        = 1'b1;
                        rsp_next.completion_time = now_inc;
                        rsp_next.turnaround_time = tat;
                        rsp_next.waiting_time    = wt;
                        rsp_next.response_time   = resp_t16;
                    end
                end
            end
            rsp_next.all_done = &(done_next | ~active_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= '0;
            done_reg      <= '0;
            now_reg       <= '0;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            done_reg      <= done_next;
            now_reg       <= now_next;
            idx_reg       <= idx_next;
            found_reg     <= found_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        best_slot_reg <= best_slot_next;
        best_prio_reg <= best_prio_next;
        best_arr_reg  <= best_arr_next;
        rsp_reg       <= rsp_next;
        if (wr_en)
        begin
            entry_reg[wr_addr] <= entry_next;
        end
    end

    assign rsp_valid       = rsp_valid_reg;
    assign rsp             = rsp_reg;
    assign sts.req_is_tick = (req.operation == OP_TICK);
    assign sts.scan_last   = (idx_reg == SLOT_W'(PROCESSES - 1));
    assign sts.out_free    = !rsp_valid_reg || !rsp_stall;

    `PPS_ASSERT(a_time_never_falls, clk, rst_n, now_reg >= $past(now_reg))
    `PPS_ASSERT_IMPL(a_finish_needs_run, clk, rst_n, rsp_valid_reg && rsp_reg.finished, rsp_reg.ran_valid)
    `PPS_ASSERT_NEXT(a_commit_fills_output, clk, rst_n, cmd.commit, rsp_valid_reg)

endmodule

/* rtl/preemptive_priority_scheduler_core.sv */
// top level of the preemptive priority scheduler
// depends on pps_pkg, pps_ctrl and pps_datapath
`timescale 1ns / 1ps

// usage
// request channel: req_valid, req_stall, req (pps_pkg::req_t). operation load
// writes one process slot; operation tick runs the scheduler for one time unit.
// response channel: rsp_valid, rsp_stall, rsp (pps_pkg::rsp_t), one response
// transfer for every request transfer, in order.
// a tick walks the slot table one slot per clock to find the winner, then
// commits its result; a load goes straight to the commit. one request is
// in flight at a time: a new request is taken only once the last one has
// committed.
// the response sits in an output register: the next request is taken while
// it waits, and the commit of that request holds until the old response has
// left. a stalled response keeps its value.
// reset clears the time, the active and done marks and all control state;
// after reset no slot is active; the response register itself is not reset.

module preemptive_priority_scheduler_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  pps_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output pps_pkg::rsp_t rsp
);
    import pps_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    pps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    pps_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
